// File: hdl/cbf_pkg.sv
// Shared types, constants and helpers for the circuit breaker block.
`timescale 1ns / 1ps

package cbf_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned LIM_W      = 16;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    // failures*100 and pct*total both fit in 39 bits
    localparam int unsigned PROD_W     = 39;

    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
    localparam logic [PROD_W-1:0] PCT_SCALE = PROD_W'(100);

    // Register reset values
    localparam logic [LIM_W-1:0] FAIL_LIMIT_RST    = LIM_W'(5);
    localparam logic [LIM_W-1:0] SUCCESS_LIMIT_RST = LIM_W'(2);
    localparam logic [NOW_W-1:0] OPEN_WAIT_RST     = NOW_W'(30000);
    localparam logic             RATE_MODE_RST     = 1'b0;
    localparam logic [LIM_W-1:0] MIN_VOLUME_RST    = LIM_W'(10);
    localparam logic [PCT_W-1:0] RATE_PCT_RST      = PCT_W'(50);

    typedef enum logic [CMD_W-1:0] {
        CMD_CHECK       = 3'd0,
        CMD_SUCCESS     = 3'd1,
        CMD_FAILURE     = 3'd2,
        CMD_TIMEOUT     = 3'd3,
        CMD_TRIP        = 3'd4,
        CMD_RESET       = 3'd5,
        CMD_FORCE_CLOSE = 3'd6,
        CMD_FORCE_OPEN  = 3'd7
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAIL_LIMIT    = 3'd0,
        CFG_SUCCESS_LIMIT = 3'd1,
        CFG_OPEN_WAIT     = 3'd2,
        CFG_RATE_MODE     = 3'd3,
        CFG_MIN_VOLUME    = 3'd4,
        CFG_RATE_PCT      = 3'd5
    } t_cfg_idx;

    // External mode codes
    localparam logic [MODE_W-1:0] MODE_CODE_CLOSED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_OPEN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_HALF   = 2'd2;

    typedef enum logic [2:0] {
        MODE_CLOSED = 3'b001,
        MODE_OPEN   = 3'b010,
        MODE_HALF   = 3'b100
    } t_mode;

    // Classified event, one flag per command
    typedef struct packed {
        logic is_check;
        logic is_success;
        logic is_failure;
        logic is_timeout;
        logic is_trip;
        logic is_reset;
        logic is_force_close;
        logic is_force_open;
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [NOW_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic             allowed;
        logic [MODE_W-1:0] mode_now;
        logic [MODE_W-1:0] mode_before;
        logic             changed;
        logic [CNT_W-1:0] total_count;
        logic [CNT_W-1:0] success_count;
        logic [CNT_W-1:0] failure_count;
        logic [CNT_W-1:0] timeout_count;
        logic [CNT_W-1:0] rejected_count;
        logic [CNT_W-1:0] trip_count;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        unique case (m)
            MODE_CLOSED: c = MODE_CODE_CLOSED;
            MODE_OPEN:   c = MODE_CODE_OPEN;
            MODE_HALF:   c = MODE_CODE_HALF;
            default:     c = MODE_CODE_CLOSED;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/cbf_front.sv
// Front end: input handshake and command classification into the queue.
`timescale 1ns / 1ps

module cbf_front (
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [cbf_pkg::CMD_W-1:0] i_cmd,
    input  logic [cbf_pkg::NOW_W-1:0] i_now_ms,
    input  logic                      i_q_full,
    output logic                      o_push,
    output cbf_pkg::t_item            o_item
);
    import cbf_pkg::*;

    t_op w_op;

    always_comb begin
        w_op = '0;
        unique case (t_cmd'(i_cmd))
            CMD_CHECK:       w_op.is_check       = 1'b1;
            CMD_SUCCESS:     w_op.is_success     = 1'b1;
            CMD_FAILURE:     w_op.is_failure     = 1'b1;
            // a timeout also counts as a failure
            CMD_TIMEOUT: begin
                w_op.is_failure = 1'b1;
                w_op.is_timeout = 1'b1;
            end
            CMD_TRIP:        w_op.is_trip        = 1'b1;
            CMD_RESET:       w_op.is_reset       = 1'b1;
            CMD_FORCE_CLOSE: w_op.is_force_close = 1'b1;
            CMD_FORCE_OPEN:  w_op.is_force_open  = 1'b1;
            default:         w_op.is_force_open  = 1'b1;
        endcase
    end

    assign o_ready       = !i_q_full;
    assign o_push        = i_valid && !i_q_full;
    assign o_item.op     = w_op;
    assign o_item.now_ms = i_now_ms;

endmodule

// File: hdl/cbf_queue.sv
// Small FIFO between the classifier and the execution stage.
`timescale 1ns / 1ps

module cbf_queue #(
    parameter int unsigned DEPTH = cbf_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cbf_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output cbf_pkg::t_item o_item,
    input  logic           i_pop
);
    import cbf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: hdl/cbf_back.sv
// Execution stage: breaker state, statistics, registers and result register.
`timescale 1ns / 1ps

module cbf_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    input  cbf_pkg::t_item                 i_item,
    output logic                           o_pop,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output cbf_pkg::t_result               o_res
);
    import cbf_pkg::*;

    // registers
    logic [LIM_W-1:0] r_fail_limit;
    logic [LIM_W-1:0] r_success_limit;
    logic [NOW_W-1:0] r_open_wait;
    logic             r_rate_mode;
    logic [LIM_W-1:0] r_min_volume;
    logic [PCT_W-1:0] r_rate_pct;

    // breaker state
    t_mode            r_mode,        n_mode;
    logic [CNT_W-1:0] r_fail_run,    n_fail_run;
    logic [CNT_W-1:0] r_success_run, n_success_run;
    logic [NOW_W-1:0] r_opened,      n_opened;
    logic [CNT_W-1:0] r_total,       n_total;
    logic [CNT_W-1:0] r_success,     n_success;
    logic [CNT_W-1:0] r_failure,     n_failure;
    logic [CNT_W-1:0] r_timeout,     n_timeout;
    logic [CNT_W-1:0] r_rejected,    n_rejected;
    logic [CNT_W-1:0] r_trips,       n_trips;
    // running products: failures*100 and rate_pct*total
    logic [PROD_W-1:0] r_fail_x100,  n_fail_x100;
    logic [PROD_W-1:0] r_pct_total,  n_pct_total;

    logic              r_res_valid;
    t_result           r_res;

    logic              w_step;
    logic              w_allowed;
    logic              w_changed;
    logic              w_trip_hit;
    logic [NOW_W-1:0]  w_elapsed;
    logic [PROD_W-1:0] w_pct_prod;
    t_op               w_op;

    assign w_op      = i_item.op;
    assign w_step    = i_valid && (!r_res_valid || i_res_ready);
    assign o_pop     = w_step;
    assign w_elapsed = i_item.now_ms - r_opened;

    // rebuild rate_pct*total when rate_pct is rewritten
    assign w_pct_prod = {{(PROD_W-PCT_W){1'b0}}, i_cfg_data[PCT_W-1:0]}
                      * {{(PROD_W-CNT_W){1'b0}}, r_total};

    always_comb begin
        n_mode        = r_mode;
        n_fail_run    = r_fail_run;
        n_success_run = r_success_run;
        n_opened      = r_opened;
        n_total       = r_total;
        n_success     = r_success;
        n_failure     = r_failure;
        n_timeout     = r_timeout;
        n_rejected    = r_rejected;
        n_trips       = r_trips;
        n_fail_x100   = r_fail_x100;
        n_pct_total   = r_pct_total;
        w_allowed     = 1'b0;
        w_changed     = 1'b0;
        w_trip_hit    = 1'b0;

        if (w_op.is_check) begin
            if (r_mode == MODE_OPEN) begin
                if (w_elapsed >= r_open_wait) begin
                    n_mode        = MODE_HALF;
                    n_success_run = '0;
                    w_changed     = 1'b1;
                    w_allowed     = 1'b1;
                end else begin
                    n_rejected = sat_inc(r_rejected);
                end
            end else begin
                w_allowed = 1'b1;
            end
        end else if (w_op.is_success) begin
            n_total       = sat_inc(r_total);
            n_success     = sat_inc(r_success);
            n_pct_total   = (r_total == CNT_MAX) ? r_pct_total
                          : r_pct_total + {{(PROD_W-PCT_W){1'b0}}, r_rate_pct};
            n_fail_run    = '0;
            n_success_run = sat_inc(r_success_run);
            if (r_mode == MODE_HALF &&
                n_success_run >= {{(CNT_W-LIM_W){1'b0}}, r_success_limit}) begin
                n_mode    = MODE_CLOSED;
                w_changed = 1'b1;
            end
        end else if (w_op.is_failure) begin
            if (w_op.is_timeout) begin
                n_timeout = sat_inc(r_timeout);
            end
            n_total       = sat_inc(r_total);
            n_failure     = sat_inc(r_failure);
            n_fail_x100   = (r_failure == CNT_MAX) ? r_fail_x100 : r_fail_x100 + PCT_SCALE;
            n_pct_total   = (r_total == CNT_MAX) ? r_pct_total
                          : r_pct_total + {{(PROD_W-PCT_W){1'b0}}, r_rate_pct};
            n_success_run = '0;
            n_fail_run    = sat_inc(r_fail_run);
            if (r_rate_mode) begin
                w_trip_hit = (n_total >= {{(CNT_W-LIM_W){1'b0}}, r_min_volume})
                          && (n_fail_x100 >= n_pct_total);
            end else begin
                w_trip_hit = n_fail_run >= {{(CNT_W-LIM_W){1'b0}}, r_fail_limit};
            end
            // a failure in half-open reopens even without a trip
            if (w_trip_hit || r_mode == MODE_HALF) begin
                n_mode    = MODE_OPEN;
                n_opened  = i_item.now_ms;
                w_changed = (r_mode != MODE_OPEN);
            end
            if (w_trip_hit) begin
                n_trips = sat_inc(r_trips);
            end
        end else if (w_op.is_trip) begin
            n_mode    = MODE_OPEN;
            n_opened  = i_item.now_ms;
            n_trips   = sat_inc(r_trips);
            w_changed = (r_mode != MODE_OPEN);
        end else if (w_op.is_reset) begin
            // opened time is kept
            n_mode        = MODE_CLOSED;
            w_changed     = (r_mode != MODE_CLOSED);
            n_fail_run    = '0;
            n_success_run = '0;
            n_total       = '0;
            n_success     = '0;
            n_failure     = '0;
            n_timeout     = '0;
            n_rejected    = '0;
            n_trips       = '0;
            n_fail_x100   = '0;
            n_pct_total   = '0;
        end else if (w_op.is_force_close) begin
            n_mode        = MODE_CLOSED;
            n_fail_run    = '0;
            n_success_run = '0;
        end else begin
            n_mode   = MODE_OPEN;
            n_opened = i_item.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_limit    <= FAIL_LIMIT_RST;
            r_success_limit <= SUCCESS_LIMIT_RST;
            r_open_wait     <= OPEN_WAIT_RST;
            r_rate_mode     <= RATE_MODE_RST;
            r_min_volume    <= MIN_VOLUME_RST;
            r_rate_pct      <= RATE_PCT_RST;
            r_mode          <= MODE_CLOSED;
            r_fail_run      <= '0;
            r_success_run   <= '0;
            r_opened        <= '0;
            r_total         <= '0;
            r_success       <= '0;
            r_failure       <= '0;
            r_timeout       <= '0;
            r_rejected      <= '0;
            r_trips         <= '0;
            r_fail_x100     <= '0;
            r_pct_total     <= '0;
            r_res_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FAIL_LIMIT:    r_fail_limit    <= i_cfg_data[LIM_W-1:0];
                    CFG_SUCCESS_LIMIT: r_success_limit <= i_cfg_data[LIM_W-1:0];
                    CFG_OPEN_WAIT:     r_open_wait     <= i_cfg_data[NOW_W-1:0];
                    CFG_RATE_MODE:     r_rate_mode     <= i_cfg_data[0];
                    CFG_MIN_VOLUME:    r_min_volume    <= i_cfg_data[LIM_W-1:0];
                    CFG_RATE_PCT:      r_rate_pct      <= i_cfg_data[PCT_W-1:0];
                    default: ;
                endcase
            end
            if (w_step) begin
                r_mode        <= n_mode;
                r_fail_run    <= n_fail_run;
                r_success_run <= n_success_run;
                r_opened      <= n_opened;
                r_total       <= n_total;
                r_success     <= n_success;
                r_failure     <= n_failure;
                r_timeout     <= n_timeout;
                r_rejected    <= n_rejected;
                r_trips       <= n_trips;
                r_fail_x100   <= n_fail_x100;
            end
            // writes must come only while idle; the block does not enforce it, and a rate_pct write wins
            if (i_cfg_we && t_cfg_idx'(i_cfg_idx) == CFG_RATE_PCT) begin
                r_pct_total <= w_pct_prod;
            end else if (w_step) begin
                r_pct_total <= n_pct_total;
            end
            if (w_step) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res.allowed        <= w_allowed;
            r_res.mode_now       <= mode_code(n_mode);
            r_res.mode_before    <= mode_code(r_mode);
            r_res.changed        <= w_changed;
            r_res.total_count    <= n_total;
            r_res.success_count  <= n_success;
            r_res.failure_count  <= n_failure;
            r_res.timeout_count  <= n_timeout;
            r_res.rejected_count <= n_rejected;
            r_res.trip_count     <= n_trips;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// File: hdl/circuit_breaker_fsm_top.sv
// Top level of the three-state circuit breaker.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  -------------------------------------
//  in        input      i_in_valid / o_in_ready   i_cmd, i_now_ms
//  out       output     o_out_valid / i_out_ready o_allowed .. o_trip_count
//  cfg       input      i_cfg_we (no stall)       i_cfg_idx, i_cfg_data
//
//  One transaction per cycle sustained while the output is not stalled; an accepted input
//  is written into the queue, and the execution step then registers its result.
//  The execution stage closes its state loop through its own registers, which sets the rate.
//  Synchronous active-low reset restores register defaults, closes the breaker and
//  clears all statistics. A stalled output holds its result; the queue absorbs
//  inputs and drops o_in_ready only when it is full.
//
//  The failure-rate test keeps failures*100 and rate_pct*total as running sums,
//  so the trip decision is an add and a compare; rate_pct writes rebuild the
//  second product once.

module circuit_breaker_fsm_top #(
    parameter int unsigned QUEUE_DEPTH = cbf_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [cbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input events
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [cbf_pkg::CMD_W-1:0]      i_cmd,
    input  logic [cbf_pkg::NOW_W-1:0]      i_now_ms,
    // results
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_allowed,
    output logic [cbf_pkg::MODE_W-1:0]     o_mode_now,
    output logic [cbf_pkg::MODE_W-1:0]     o_mode_before,
    output logic                           o_changed,
    output logic [cbf_pkg::CNT_W-1:0]      o_total_count,
    output logic [cbf_pkg::CNT_W-1:0]      o_success_count,
    output logic [cbf_pkg::CNT_W-1:0]      o_failure_count,
    output logic [cbf_pkg::CNT_W-1:0]      o_timeout_count,
    output logic [cbf_pkg::CNT_W-1:0]      o_rejected_count,
    output logic [cbf_pkg::CNT_W-1:0]      o_trip_count
);
    import cbf_pkg::*;

    logic    w_q_full;
    logic    w_push;
    t_item   w_push_item;
    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_pop;
    t_result w_res;

    // classify the event and hand it to the queue
    cbf_front u_front (
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_cmd    (i_cmd),
        .i_now_ms (i_now_ms),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    cbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    // breaker state, stats and the output register
    cbf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (w_res)
    );

    assign o_allowed        = w_res.allowed;
    assign o_mode_now       = w_res.mode_now;
    assign o_mode_before    = w_res.mode_before;
    assign o_changed        = w_res.changed;
    assign o_total_count    = w_res.total_count;
    assign o_success_count  = w_res.success_count;
    assign o_failure_count  = w_res.failure_count;
    assign o_timeout_count  = w_res.timeout_count;
    assign o_rejected_count = w_res.rejected_count;
    assign o_trip_count     = w_res.trip_count;

endmodule

// File: hdl/cbf_checker.sv
// Port-level assertions for the circuit breaker, bound to the top level.
`timescale 1ns / 1ps

module cbf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_allowed,
    input logic [cbf_pkg::MODE_W-1:0]     o_mode_now,
    input logic [cbf_pkg::MODE_W-1:0]     o_mode_before,
    input logic                           o_changed,
    input logic [cbf_pkg::CNT_W-1:0]      o_total_count,
    input logic [cbf_pkg::CNT_W-1:0]      o_success_count,
    input logic [cbf_pkg::CNT_W-1:0]      o_failure_count,
    input logic [cbf_pkg::CNT_W-1:0]      o_timeout_count,
    input logic [cbf_pkg::CNT_W-1:0]      o_trip_count
);
    import cbf_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_mode_now)
            && $stable(o_total_count) && $stable(o_trip_count))
        else $error("result changed while stalled");

    // a reported change really moves the state
    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_changed |-> o_mode_now != o_mode_before)
        else $error("changed flag without a state change");

    // a granted request never leaves the breaker open
    a_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_allowed |-> o_mode_now != MODE_CODE_OPEN)
        else $error("request allowed while open");

    // totals bound their parts
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_total_count >= o_success_count
            && o_total_count >= o_failure_count
            && o_failure_count >= o_timeout_count)
        else $error("statistics inconsistent");

endmodule

bind circuit_breaker_fsm_top cbf_checker u_cbf_checker (.*);
